### rtl/binned_track_moment_histogram_assert.svh
`ifndef BINNED_TRACK_MOMENT_HISTOGRAM_ASSERT_SVH
`define BINNED_TRACK_MOMENT_HISTOGRAM_ASSERT_SVH
// -----------------------------------------------------------------------------
// Assertion macros for the binned track moment histogram.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// -----------------------------------------------------------------------------

// The consequent must hold in the same cycle as the antecedent.
`define BTMH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btmh_pkg.sv
// -----------------------------------------------------------------------------
// btmh_pkg
// Shared types and constants of the binned track moment histogram: command
// and status codes, controller states, bin accumulator layout.
// -----------------------------------------------------------------------------
package btmh_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned SQ_W   = 48;
  localparam int unsigned PT_W   = 16;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned NBIN_W = 4;

  // Number of regular pt bins after reset.
  localparam logic [NBIN_W-1:0] PT_BINS_RESET = 4'd8;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_NEW_EVENT    = 2'd0,
    CMD_ADD_TRACK    = 2'd1,
    CMD_SET_REF_MULT = 2'd2,
    CMD_QUERY        = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_PHI_NEG = 3'd1,
    STAT_PHI_BIG = 3'd2,
    STAT_ETA_NEG = 3'd3,
    STAT_ETA_BIG = 3'd4,
    STAT_PT_NEG  = 3'd5,
    STAT_PT_BIG  = 3'd6,
    STAT_DROPPED = 3'd7
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WORK  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_e;

  // One bin of one charge set as stored in memory.
  typedef struct packed {
    logic [SQ_W-1:0]  ptsq_sum;
    logic [SUM_W-1:0] pt_sum;
    logic [CNT_W-1:0] count;
  } bin_acc_t;

  // Decoded operation handed from the decoder to the controller.
  typedef struct packed {
    status_e status;
    logic    to_plus;
    logic    to_minus;
    logic    query_ok;
  } bin_op_t;

endpackage

### rtl/binned_track_moment_histogram.sv
// -----------------------------------------------------------------------------
// binned_track_moment_histogram
// Per-event histogram of tracks over pt, phi and eta bins, one set per charge
// sign, each bin holding a count, a pt sum and a pt squared sum.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   command, indices, charge, pt,
//                                                 reference multiplicity value
//   out      output     out_valid_o / out_ready_i status, reference
//                                                 multiplicity, bin moments
//   cfg      input      cfg_valid_i / cfg_ready_o number of pt bins in use
//
// Add, set and query transactions read the bin memories, then update, write
// back and load the output register. New event runs a sweep that zeroes the
// bin memories one entry per cycle, the last entry rewritten while the output
// is stalled, over DEPTH = (MAX_PT_BINS+1)*PHI_BINS*ETA_BINS entries. After
// reset the same sweep runs over all DEPTH entries before in_ready_o rises.
// A stalled output holds the controller in its last step; cfg is always ready.
// -----------------------------------------------------------------------------
`include "binned_track_moment_histogram_assert.svh"

module binned_track_moment_histogram #(
  parameter int unsigned MAX_PT_BINS = 8,
  parameter int unsigned PHI_BINS    = 16,
  parameter int unsigned ETA_BINS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input transactions.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [btmh_pkg::CMD_W-1:0]        command_i,
  input  logic signed [5:0]                 phi_index_i,
  input  logic signed [5:0]                 eta_index_i,
  input  logic signed [4:0]                 pt_index_i,
  input  logic signed [1:0]                 charge_sign_i,
  input  logic [btmh_pkg::PT_W-1:0]         track_pt_i,
  input  logic [btmh_pkg::REF_W-1:0]        ref_mult_value_i,
  // Result transactions.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [btmh_pkg::REF_W-1:0]        ref_mult_o,
  output logic [btmh_pkg::CNT_W-1:0]        count_plus_o,
  output logic [btmh_pkg::CNT_W-1:0]        count_minus_o,
  output logic [btmh_pkg::CNT_W:0]          count_total_o,
  output logic signed [btmh_pkg::CNT_W:0]   count_difference_o,
  output logic [btmh_pkg::SUM_W-1:0]        pt_sum_plus_o,
  output logic [btmh_pkg::SUM_W-1:0]        pt_sum_minus_o,
  output logic [btmh_pkg::SUM_W:0]          pt_sum_total_o,
  output logic [btmh_pkg::SQ_W-1:0]         ptsq_sum_plus_o,
  output logic [btmh_pkg::SQ_W-1:0]         ptsq_sum_minus_o,
  output logic [btmh_pkg::SQ_W:0]           ptsq_sum_total_o,
  // Configuration write.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [btmh_pkg::NBIN_W-1:0]       cfg_data_i
);
  import btmh_pkg::*;

  localparam int unsigned DEPTH  = (MAX_PT_BINS + 1) * PHI_BINS * ETA_BINS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W  = $bits(bin_acc_t);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [NBIN_W-1:0] MAX_NBINS = NBIN_W'(MAX_PT_BINS);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [REF_W-1:0]    ref_q, ref_d;
  logic                auto_q, auto_d;
  logic [NBIN_W-1:0]   pt_bins_q, nbins;

  logic                in_accept, out_free, sweep, emit_work, emit_clear;
  cmd_e                in_cmd;

  logic [ADDR_W-1:0]   dec_addr, addr_q;
  bin_op_t             dec_op, op_q;
  logic [PT_W-1:0]     pt_q;
  logic [2*PT_W-1:0]   sq_q;

  bin_acc_t            rd_plus, rd_minus, upd_plus, upd_minus;
  logic                we_plus, we_minus;
  logic [ADDR_W-1:0]   waddr;
  bin_acc_t            wdata_plus, wdata_minus;

  logic [CNT_W:0]        cnt_total;
  logic signed [CNT_W:0] cnt_diff;
  logic [SUM_W:0]        sum_total;
  logic [SQ_W:0]         sq_total;

  logic                  out_valid_q;
  status_e               status_q;
  logic [REF_W-1:0]      ref_out_q;
  bin_acc_t              res_plus_q, res_minus_q;
  logic [CNT_W:0]        cnt_total_q;
  logic signed [CNT_W:0] cnt_diff_q;
  logic [SUM_W:0]        sum_total_q;
  logic [SQ_W:0]         sq_total_q;

  // Handshakes.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_cmd      = cmd_e'(command_i);

  // Bin count in use, limited to the built-in maximum.
  assign nbins = (pt_bins_q > MAX_NBINS) ? MAX_NBINS : pt_bins_q;

  btmh_decode #(
    .PHI_BINS (PHI_BINS),
    .ETA_BINS (ETA_BINS),
    .ADDR_W   (ADDR_W)
  ) u_decode (
    .command_i     (command_i),
    .phi_index_i   (phi_index_i),
    .eta_index_i   (eta_index_i),
    .pt_index_i    (pt_index_i),
    .charge_sign_i (charge_sign_i),
    .nbins_i       (nbins),
    .addr_o        (dec_addr),
    .op_o          (dec_op)
  );

  // Controller: clearing sweep, idle, read-modify-write step.
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    sweep      = 1'b0;
    emit_work  = 1'b0;
    emit_clear = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        sweep = 1'b1;
        if (clr_cnt_q == LAST_ADDR) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (in_cmd == CMD_NEW_EVENT) ? ST_CLEAR : ST_WORK;
        end
      end
      ST_WORK: begin
        if (out_free) begin
          emit_work = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        sweep = 1'b1;
        if (clr_cnt_q == LAST_ADDR) begin
          // The last entry is simply rewritten while the output is stalled.
          if (out_free) begin
            emit_clear = 1'b1;
            clr_cnt_d  = '0;
            state_d    = ST_IDLE;
          end
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // Reference multiplicity and its automatic count.
  always_comb begin
    ref_d  = ref_q;
    auto_d = auto_q;
    if (in_accept) begin
      unique case (in_cmd)
        CMD_NEW_EVENT: begin
          ref_d  = '0;
          auto_d = 1'b1;
        end
        CMD_ADD_TRACK: begin
          if (auto_q && (ref_q != '1)) begin
            ref_d = ref_q + REF_W'(1);
          end
        end
        CMD_SET_REF_MULT: begin
          ref_d  = ref_mult_value_i;
          auto_d = 1'b0;
        end
        CMD_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      clr_cnt_q <= '0;
      ref_q     <= '0;
      auto_q    <= 1'b1;
      pt_bins_q <= PT_BINS_RESET;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      ref_q     <= ref_d;
      auto_q    <= auto_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pt_bins_q <= cfg_data_i;
      end
    end
  end

  // Transaction registers, loaded as the bin read is issued.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= dec_op;
      addr_q <= dec_addr;
      pt_q   <= track_pt_i;
      sq_q   <= (2*PT_W)'(track_pt_i) * (2*PT_W)'(track_pt_i);
    end
  end

  // Bin memories, one per charge set.
  assign we_plus     = sweep || (emit_work && op_q.to_plus);
  assign we_minus    = sweep || (emit_work && op_q.to_minus);
  assign waddr       = sweep ? clr_cnt_q : addr_q;
  assign wdata_plus  = sweep ? '0 : upd_plus;
  assign wdata_minus = sweep ? '0 : upd_minus;

  btmh_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_ram_plus (
    .clk_i   (clk_i),
    .we_i    (we_plus),
    .waddr_i (waddr),
    .wdata_i (wdata_plus),
    .re_i    (in_accept),
    .raddr_i (dec_addr),
    .rdata_o (rd_plus)
  );

  btmh_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_ram_minus (
    .clk_i   (clk_i),
    .we_i    (we_minus),
    .waddr_i (waddr),
    .wdata_i (wdata_minus),
    .re_i    (in_accept),
    .raddr_i (dec_addr),
    .rdata_o (rd_minus)
  );

  btmh_accum u_accum (
    .plus_i           (rd_plus),
    .minus_i          (rd_minus),
    .track_pt_i       (pt_q),
    .pt_sq_i          (sq_q),
    .plus_upd_o       (upd_plus),
    .minus_upd_o      (upd_minus),
    .count_total_o    (cnt_total),
    .count_diff_o     (cnt_diff),
    .pt_sum_total_o   (sum_total),
    .ptsq_sum_total_o (sq_total)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_work || emit_clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; bin fields are zero unless a query succeeded.
  always_ff @(posedge clk_i) begin
    if (emit_work || emit_clear) begin
      status_q  <= emit_work ? op_q.status : STAT_OK;
      ref_out_q <= ref_q;
      if (emit_work && op_q.query_ok) begin
        res_plus_q  <= rd_plus;
        res_minus_q <= rd_minus;
        cnt_total_q <= cnt_total;
        cnt_diff_q  <= cnt_diff;
        sum_total_q <= sum_total;
        sq_total_q  <= sq_total;
      end else begin
        res_plus_q  <= '0;
        res_minus_q <= '0;
        cnt_total_q <= '0;
        cnt_diff_q  <= '0;
        sum_total_q <= '0;
        sq_total_q  <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign ref_mult_o         = ref_out_q;
  assign count_plus_o       = res_plus_q.count;
  assign count_minus_o      = res_minus_q.count;
  assign count_total_o      = cnt_total_q;
  assign count_difference_o = cnt_diff_q;
  assign pt_sum_plus_o      = res_plus_q.pt_sum;
  assign pt_sum_minus_o     = res_minus_q.pt_sum;
  assign pt_sum_total_o     = sum_total_q;
  assign ptsq_sum_plus_o    = res_plus_q.ptsq_sum;
  assign ptsq_sum_minus_o   = res_minus_q.ptsq_sum;
  assign ptsq_sum_total_o   = sq_total_q;

  // Assertions.
  `BTMH_ASSERT_NEXT(a_rmw_follows, in_accept && (in_cmd != CMD_NEW_EVENT), state_q == ST_WORK, "accepted bin transaction did not enter the update step")
  `BTMH_ASSERT_NEXT(a_ref_hold, !in_accept, $stable(ref_q) && $stable(auto_q), "reference multiplicity changed without a transaction")
  `BTMH_ASSERT_SAME(a_out_source, $rose(out_valid_q), ($past(state_q) == ST_WORK) || ($past(state_q) == ST_CLEAR), "result appeared outside the update or clear step")
  `BTMH_ASSERT_SAME(a_idle_cnt, state_q == ST_IDLE, clr_cnt_q == '0, "clear counter not rewound after the sweep")

endmodule

### rtl/btmh_ram.sv
// -----------------------------------------------------------------------------
// btmh_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// -----------------------------------------------------------------------------
module btmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/btmh_decode.sv
// -----------------------------------------------------------------------------
// btmh_decode
// Range checks of an incoming transaction and bin address computation.
// -----------------------------------------------------------------------------
module btmh_decode #(
  parameter int unsigned PHI_BINS = 16,
  parameter int unsigned ETA_BINS = 16,
  parameter int unsigned ADDR_W   = 12
) (
  input  logic [btmh_pkg::CMD_W-1:0]  command_i,
  input  logic signed [5:0]           phi_index_i,
  input  logic signed [5:0]           eta_index_i,
  input  logic signed [4:0]           pt_index_i,
  input  logic signed [1:0]           charge_sign_i,
  input  logic [btmh_pkg::NBIN_W-1:0] nbins_i,
  output logic [ADDR_W-1:0]           addr_o,
  output btmh_pkg::bin_op_t           op_o
);
  import btmh_pkg::*;

  localparam logic [4:0] PHI_LIM = 5'(PHI_BINS);
  localparam logic [4:0] ETA_LIM = 5'(ETA_BINS);

  cmd_e              cmd;
  logic              phi_neg, phi_big, eta_neg, eta_big;
  logic              pt_neg, pt_over, pt_big, in_range;
  logic [NBIN_W-1:0] pt_mag, bin_pt;

  // Index checks.
  always_comb begin
    cmd      = cmd_e'(command_i);
    phi_neg  = phi_index_i[5];
    phi_big  = !phi_index_i[5] && (phi_index_i[4:0] >= PHI_LIM);
    eta_neg  = eta_index_i[5];
    eta_big  = !eta_index_i[5] && (eta_index_i[4:0] >= ETA_LIM);
    pt_neg   = pt_index_i[4];
    pt_mag   = pt_index_i[3:0];
    pt_over  = pt_neg || (pt_mag >= nbins_i);
    pt_big   = !pt_neg && (pt_mag > nbins_i);
    in_range = !(phi_neg || phi_big || eta_neg || eta_big);
    // Tracks outside the regular pt bins land in the overflow bin.
    bin_pt   = ((cmd == CMD_ADD_TRACK) && pt_over) ? nbins_i : pt_mag;
  end

  // Linear bin address: pt bin major, then phi, then eta.
  assign addr_o = (ADDR_W'(bin_pt) * ADDR_W'(PHI_BINS) + ADDR_W'(phi_index_i[4:0]))
                  * ADDR_W'(ETA_BINS) + ADDR_W'(eta_index_i[4:0]);

  // Operation and status.
  always_comb begin
    op_o          = '0;
    op_o.status   = STAT_OK;
    unique case (cmd)
      CMD_NEW_EVENT: begin
      end
      CMD_ADD_TRACK: begin
        if (!in_range) begin
          op_o.status = STAT_DROPPED;
        end else begin
          op_o.to_plus  = !charge_sign_i[1] && charge_sign_i[0];
          op_o.to_minus = charge_sign_i[1];
        end
      end
      CMD_SET_REF_MULT: begin
      end
      CMD_QUERY: begin
        priority if (phi_neg) begin
          op_o.status = STAT_PHI_NEG;
        end else if (phi_big) begin
          op_o.status = STAT_PHI_BIG;
        end else if (eta_neg) begin
          op_o.status = STAT_ETA_NEG;
        end else if (eta_big) begin
          op_o.status = STAT_ETA_BIG;
        end else if (pt_neg) begin
          op_o.status = STAT_PT_NEG;
        end else if (pt_big) begin
          op_o.status = STAT_PT_BIG;
        end else begin
          op_o.query_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/btmh_accum.sv
// -----------------------------------------------------------------------------
// btmh_accum
// Saturating bin update and the combined sums returned by a query.
// -----------------------------------------------------------------------------
module btmh_accum (
  input  btmh_pkg::bin_acc_t             plus_i,
  input  btmh_pkg::bin_acc_t             minus_i,
  input  logic [btmh_pkg::PT_W-1:0]      track_pt_i,
  input  logic [2*btmh_pkg::PT_W-1:0]    pt_sq_i,
  output btmh_pkg::bin_acc_t             plus_upd_o,
  output btmh_pkg::bin_acc_t             minus_upd_o,
  output logic [btmh_pkg::CNT_W:0]       count_total_o,
  output logic signed [btmh_pkg::CNT_W:0] count_diff_o,
  output logic [btmh_pkg::SUM_W:0]       pt_sum_total_o,
  output logic [btmh_pkg::SQ_W:0]        ptsq_sum_total_o
);
  import btmh_pkg::*;

  // Adds one track to a bin, each field held at its top value.
  function automatic bin_acc_t sat_update(bin_acc_t acc, logic [PT_W-1:0] pt,
                                          logic [2*PT_W-1:0] sq);
    bin_acc_t       res;
    logic [CNT_W:0] cnt_sum;
    logic [SUM_W:0] pt_sum;
    logic [SQ_W:0]  sq_sum;
    cnt_sum      = {1'b0, acc.count} + (CNT_W+1)'(1);
    pt_sum       = {1'b0, acc.pt_sum} + (SUM_W+1)'(pt);
    sq_sum       = {1'b0, acc.ptsq_sum} + (SQ_W+1)'(sq);
    res.count    = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    res.pt_sum   = pt_sum[SUM_W] ? '1 : pt_sum[SUM_W-1:0];
    res.ptsq_sum = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    return res;
  endfunction

  // Updated bins for both charge sets; the controller writes at most one of them.
  assign plus_upd_o  = sat_update(plus_i, track_pt_i, pt_sq_i);
  assign minus_upd_o = sat_update(minus_i, track_pt_i, pt_sq_i);

  // Query totals.
  assign count_total_o    = {1'b0, plus_i.count} + {1'b0, minus_i.count};
  assign count_diff_o     = {1'b0, plus_i.count} - {1'b0, minus_i.count};
  assign pt_sum_total_o   = {1'b0, plus_i.pt_sum} + {1'b0, minus_i.pt_sum};
  assign ptsq_sum_total_o = {1'b0, plus_i.ptsq_sum} + {1'b0, minus_i.ptsq_sum};

endmodule

### sim/tb_binned_track_moment_histogram.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_binned_track_moment_histogram
// Self-checking bench for the binned track moment histogram. A queue of track
// commands feeds a valid/ready driver. Each accepted transaction updates a
// bench-side copy of the bin memories and pushes the expected result. The
// monitor compares every returned transaction field by field. The run covers
// directed corner cases, random events under several pt bin settings, a long
// receiver stall and a back-to-back burst of full-scale tracks on one bin.
// -----------------------------------------------------------------------------
module tb_binned_track_moment_histogram;
  import btmh_pkg::*;

  localparam int N_PT         = 8;
  localparam int N_PHI        = 16;
  localparam int N_ETA        = 16;
  localparam int BIN_DEPTH    = (N_PT + 1) * N_PHI * N_ETA;
  localparam int HOLD_CYCLES  = 600;
  localparam int BURST_TRACKS = 16;
  localparam int CYCLE_LIMIT  = 2000000;

  // One input transaction.
  typedef struct {
    cmd_e              cmd;
    logic signed [5:0] phi;
    logic signed [5:0] eta;
    logic signed [4:0] ptb;
    logic signed [1:0] chg;
    logic [15:0]       pt;
    logic [15:0]       rmv;
  } track_cmd_t;

  // One result transaction.
  typedef struct {
    status_e     status;
    logic [15:0] ref_mult;
    logic [15:0] cnt_p;
    logic [15:0] cnt_m;
    logic [16:0] cnt_tot;
    logic [16:0] cnt_diff;
    logic [31:0] sum_p;
    logic [31:0] sum_m;
    logic [32:0] sum_tot;
    logic [47:0] sq_p;
    logic [47:0] sq_m;
    logic [48:0] sq_tot;
  } bin_report_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i        = '0;
  logic signed [5:0] phi_index_i   = '0;
  logic signed [5:0] eta_index_i   = '0;
  logic signed [4:0] pt_index_i    = '0;
  logic signed [1:0] charge_sign_i = '0;
  logic [15:0] track_pt_i       = '0;
  logic [15:0] ref_mult_value_i = '0;

  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] ref_mult_o;
  logic [15:0] count_plus_o;
  logic [15:0] count_minus_o;
  logic [16:0] count_total_o;
  logic signed [16:0] count_difference_o;
  logic [31:0] pt_sum_plus_o;
  logic [31:0] pt_sum_minus_o;
  logic [32:0] pt_sum_total_o;
  logic [47:0] ptsq_sum_plus_o;
  logic [47:0] ptsq_sum_minus_o;
  logic [48:0] ptsq_sum_total_o;

  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i       = '0;

  // Bench-side copy of the histogram state.
  logic [15:0] plus_count   [BIN_DEPTH];
  logic [15:0] minus_count  [BIN_DEPTH];
  logic [31:0] plus_pt_sum  [BIN_DEPTH];
  logic [31:0] minus_pt_sum [BIN_DEPTH];
  logic [47:0] plus_ptsq    [BIN_DEPTH];
  logic [47:0] minus_ptsq   [BIN_DEPTH];
  logic [15:0] ref_mult_model = '0;
  logic        auto_mult_on   = 1'b1;
  logic [3:0]  pt_bins_model  = PT_BINS_RESET;

  track_cmd_t  pending_tracks[$];
  bin_report_t expected_reports[$];
  track_cmd_t  track_on_bus;
  bin_report_t want;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 60;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_left = 0;
  logic        rx_hold_arm = 1'b0;

  binned_track_moment_histogram #(
    .MAX_PT_BINS(N_PT),
    .PHI_BINS   (N_PHI),
    .ETA_BINS   (N_ETA)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .phi_index_i       (phi_index_i),
    .eta_index_i       (eta_index_i),
    .pt_index_i        (pt_index_i),
    .charge_sign_i     (charge_sign_i),
    .track_pt_i        (track_pt_i),
    .ref_mult_value_i  (ref_mult_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .ref_mult_o        (ref_mult_o),
    .count_plus_o      (count_plus_o),
    .count_minus_o     (count_minus_o),
    .count_total_o     (count_total_o),
    .count_difference_o(count_difference_o),
    .pt_sum_plus_o     (pt_sum_plus_o),
    .pt_sum_minus_o    (pt_sum_minus_o),
    .pt_sum_total_o    (pt_sum_total_o),
    .ptsq_sum_plus_o   (ptsq_sum_plus_o),
    .ptsq_sum_minus_o  (ptsq_sum_minus_o),
    .ptsq_sum_total_o  (ptsq_sum_total_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  // Saturating update of one bin of one charge set.
  function automatic void accumulate(inout logic [15:0] cnt, inout logic [31:0] sum,
                                     inout logic [47:0] sq, input logic [15:0] pt);
    logic [16:0] c17;
    logic [32:0] s33;
    logic [48:0] q49;
    logic [31:0] pt_sq;
    pt_sq = 32'(pt) * 32'(pt);
    c17 = {1'b0, cnt} + 17'd1;
    s33 = {1'b0, sum} + 33'(pt);
    q49 = {1'b0, sq} + 49'(pt_sq);
    cnt = c17[16] ? '1 : c17[15:0];
    sum = s33[32] ? '1 : s33[31:0];
    sq  = q49[48] ? '1 : q49[47:0];
  endfunction

  // Applies one command to the histogram copy and returns the expected result.
  function automatic bin_report_t histogram_apply(input track_cmd_t t);
    bin_report_t r;
    int nbins;
    int phi;
    int eta;
    int ptb;
    int chg;
    int k;
    r.status = STAT_OK;
    r.cnt_p = '0;
    r.cnt_m = '0;
    r.cnt_tot = '0;
    r.cnt_diff = '0;
    r.sum_p = '0;
    r.sum_m = '0;
    r.sum_tot = '0;
    r.sq_p = '0;
    r.sq_m = '0;
    r.sq_tot = '0;
    nbins = (pt_bins_model > N_PT) ? N_PT : int'(pt_bins_model);
    phi = t.phi;
    eta = t.eta;
    ptb = t.ptb;
    chg = t.chg;
    case (t.cmd)
      CMD_NEW_EVENT: begin
        for (int i = 0; i < BIN_DEPTH; i++) begin
          plus_count[i] = '0;
          minus_count[i] = '0;
          plus_pt_sum[i] = '0;
          minus_pt_sum[i] = '0;
          plus_ptsq[i] = '0;
          minus_ptsq[i] = '0;
        end
        ref_mult_model = '0;
        auto_mult_on = 1'b1;
      end
      CMD_ADD_TRACK: begin
        // Dropped and unbinned tracks still advance the automatic count.
        if (auto_mult_on && ref_mult_model != 16'hFFFF) ref_mult_model++;
        if (ptb < 0 || ptb >= nbins) ptb = nbins;
        if (phi < 0 || phi >= N_PHI || eta < 0 || eta >= N_ETA) begin
          r.status = STAT_DROPPED;
        end else if (chg != 0) begin
          k = (ptb * N_PHI + phi) * N_ETA + eta;
          if (chg > 0) accumulate(plus_count[k], plus_pt_sum[k], plus_ptsq[k], t.pt);
          else accumulate(minus_count[k], minus_pt_sum[k], minus_ptsq[k], t.pt);
        end
      end
      CMD_SET_REF_MULT: begin
        auto_mult_on = 1'b0;
        ref_mult_model = t.rmv;
      end
      default: begin
        // Index checks in order phi, eta, pt; the overflow bin is queryable.
        if (phi < 0) r.status = STAT_PHI_NEG;
        else if (phi >= N_PHI) r.status = STAT_PHI_BIG;
        else if (eta < 0) r.status = STAT_ETA_NEG;
        else if (eta >= N_ETA) r.status = STAT_ETA_BIG;
        else if (ptb < 0) r.status = STAT_PT_NEG;
        else if (ptb > nbins) r.status = STAT_PT_BIG;
        else begin
          k = (ptb * N_PHI + phi) * N_ETA + eta;
          r.cnt_p = plus_count[k];
          r.cnt_m = minus_count[k];
          r.cnt_tot = 17'(plus_count[k]) + 17'(minus_count[k]);
          r.cnt_diff = 17'(plus_count[k]) - 17'(minus_count[k]);
          r.sum_p = plus_pt_sum[k];
          r.sum_m = minus_pt_sum[k];
          r.sum_tot = 33'(plus_pt_sum[k]) + 33'(minus_pt_sum[k]);
          r.sq_p = plus_ptsq[k];
          r.sq_m = minus_ptsq[k];
          r.sq_tot = 49'(plus_ptsq[k]) + 49'(minus_ptsq[k]);
        end
      end
    endcase
    r.ref_mult = ref_mult_model;
    return r;
  endfunction

  function automatic track_cmd_t make_track(input cmd_e c, input int phi, input int eta,
                                            input int ptb, input int chg, input int pt,
                                            input int rmv);
    track_cmd_t t;
    t.cmd = c;
    t.phi = 6'(phi);
    t.eta = 6'(eta);
    t.ptb = 5'(ptb);
    t.chg = 2'(chg);
    t.pt  = 16'(pt);
    t.rmv = 16'(rmv);
    return t;
  endfunction

  // Random command: mostly adds and queries on a small set of bins so that
  // queries hit populated entries, with some fully random indices as noise.
  function automatic track_cmd_t random_track();
    track_cmd_t t;
    int unsigned pick;
    t = make_track(CMD_ADD_TRACK, $urandom, $urandom, $urandom,
                   int'($urandom_range(2)) - 1, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 2) begin
      t.cmd = CMD_NEW_EVENT;
    end else if (pick < 8) begin
      t.cmd = CMD_SET_REF_MULT;
      case ($urandom_range(3))
        0: t.rmv = 16'hFFFF;
        1: t.rmv = '0;
        default: t.rmv = 16'($urandom);
      endcase
    end else begin
      t.cmd = (pick < 60) ? CMD_ADD_TRACK : CMD_QUERY;
      if ($urandom_range(7) != 0) begin
        t.phi = 6'($urandom_range(3));
        t.eta = 6'($urandom_range(3));
      end
      if ($urandom_range(3) != 0) t.ptb = 5'($urandom_range(9));
      case ($urandom_range(3))
        0: t.pt = 16'hFFFF;
        1: t.pt = 16'($urandom_range(1023));
        default: t.pt = 16'($urandom);
      endcase
    end
    return t;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_tracks.push_back(random_track());
  endtask

  // Returns at a falling edge once nothing is queued, offered or outstanding.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_tracks.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write, only issued while the block is drained.
  task automatic write_pt_bins(input logic [3:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    pt_bins_model = value;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Input driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_reports.push_back(histogram_apply(track_on_bus));
      if (!in_valid_i || in_ready_o) begin
        if (pending_tracks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          track_on_bus = pending_tracks.pop_front();
          command_i        <= track_on_bus.cmd;
          phi_index_i      <= track_on_bus.phi;
          eta_index_i      <= track_on_bus.eta;
          pt_index_i       <= track_on_bus.ptb;
          charge_sign_i    <= track_on_bus.chg;
          track_pt_i       <= track_on_bus.pt;
          ref_mult_value_i <= track_on_bus.rmv;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed from the main sequence.
  always @(posedge clk_i) begin
    if (rx_hold_arm) rx_hold_left <= HOLD_CYCLES;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // Output monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t: result with nothing pending", $time);
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", want.status, status_o);
          compare_field("ref_mult", want.ref_mult, ref_mult_o);
          compare_field("count_plus", want.cnt_p, count_plus_o);
          compare_field("count_minus", want.cnt_m, count_minus_o);
          compare_field("count_total", want.cnt_tot, count_total_o);
          compare_field("count_difference", want.cnt_diff, {count_difference_o});
          compare_field("pt_sum_plus", want.sum_p, pt_sum_plus_o);
          compare_field("pt_sum_minus", want.sum_m, pt_sum_minus_o);
          compare_field("pt_sum_total", want.sum_tot, pt_sum_total_o);
          compare_field("ptsq_sum_plus", want.sq_p, ptsq_sum_plus_o);
          compare_field("ptsq_sum_minus", want.sq_m, ptsq_sum_minus_o);
          compare_field("ptsq_sum_total", want.sq_tot, ptsq_sum_total_o);
        end
      end
      out_ready_i <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < BIN_DEPTH; i++) begin
      plus_count[i] = '0;
      minus_count[i] = '0;
      plus_pt_sum[i] = '0;
      minus_pt_sum[i] = '0;
      plus_ptsq[i] = '0;
      minus_ptsq[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corner cases with the reset bin count.
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 0, 0, 0, 1, 'hFFFF, 'hFFFF));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 15, 15, 7, -1, 1, 0));
    // Negative, too large and exactly-overflow pt bins all land in the overflow bin.
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 3, 4, -16, 1, 'h8000, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 3, 4, 15, -1, 'h7FFF, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 3, 4, 8, -1, 0, 0));
    // Out-of-range phi or eta drops the track.
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, -32, 0, 0, 1, 5, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 31, 0, 0, -1, 5, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 0, -32, 0, 1, 5, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 0, 31, 0, 1, 5, 0));
    // Zero charge is counted but not binned.
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 1, 1, 0, 0, 'h1234, 0));
    // Query error codes, then valid queries including the overflow bin.
    pending_tracks.push_back(make_track(CMD_QUERY, -1, 0, 0, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 16, -1, -1, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, -1, 0, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 16, -1, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 0, -1, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 0, 9, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 3, 4, 8, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 15, 15, 7, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 1, 1, 0, 0, 0, 0));
    // A set stops the automatic count; a new event clears and restarts it.
    pending_tracks.push_back(make_track(CMD_SET_REF_MULT, 0, 0, 0, 0, 0, 'hFFFF));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 0, 0, 0, -1, 2, 0));
    pending_tracks.push_back(make_track(CMD_NEW_EVENT, 0, 0, 0, 0, 0, 0));
    pending_tracks.push_back(make_track(CMD_ADD_TRACK, 0, 0, 0, -1, 3, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 0, 0, 0, 0, 0, 0));

    // Random events; register changes keep bin contents within an event.
    write_pt_bins(4'd3);
    queue_random(200);
    write_pt_bins(4'd0);
    queue_random(80);
    wait_drained();
    send_idle_pct = 60;
    recv_idle_pct = 35;
    write_pt_bins(4'd15);
    queue_random(130);
    write_pt_bins(4'd1);
    queue_random(130);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_pt_bins(4'd8);
    queue_random(130);

    // Receiver stalls for a long stretch while the sender keeps offering.
    wait_drained();
    rx_hold_arm = 1'b1;
    queue_random(60);
    @(negedge clk_i);
    rx_hold_arm = 1'b0;

    // Back-to-back full-scale tracks of both charges on one bin after a new event.
    wait_drained();
    pending_tracks.push_back(make_track(CMD_NEW_EVENT, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < BURST_TRACKS; i++)
      pending_tracks.push_back(make_track(CMD_ADD_TRACK, 2, 5, 1, (i % 2) ? -1 : 1,
                                          'hFFFF, 0));
    pending_tracks.push_back(make_track(CMD_QUERY, 2, 5, 1, 0, 0, 0));

    write_pt_bins(4'd5);
    queue_random(40);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
